FILE: hw/rtl/target_track_table_top_defines.svh
// Assertion macros for the target track table checker.
// Include-guarded; used by target_track_table_chk only.
`ifndef TARGET_TRACK_TABLE_TOP_DEFINES_SVH
`define TARGET_TRACK_TABLE_TOP_DEFINES_SVH
// Implication checked on every clock, disabled during reset.
`define TTT_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
// Next-cycle implication, disabled during reset.
`define TTT_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`endif

FILE: hw/rtl/ttt_pkg.sv
// Shared types, constants and codes for the target track table.
// No dependencies.
package ttt_pkg;
	localparam int TABLE_DEPTH = 16;
	localparam int MAX_RESULTS = 16;
	localparam logic [7:0] SEEN_MAX = 8'd255;

	typedef enum logic [2:0] {
		FN_OBSERVE = 3'd0, FN_FIND = 3'd1, FN_LIST = 3'd2, FN_MARK = 3'd3,
		FN_FORGET = 3'd4, FN_CLEAR = 3'd5, FN_RESET = 3'd6, FN_PICKUP = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		CFG_RADIUS = 2'd0, CFG_EXPIRY = 2'd1, CFG_BATCH = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] color;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [7:0] quality;
		logic [31:0] now_ms;
		logic [15:0] target_id;
		logic [4:0] list_limit;
	} req_t;

	typedef struct packed {
		logic found;
		logic [15:0] entry_id;
		logic [7:0] entry_color;
		logic signed [15:0] entry_x;
		logic signed [15:0] entry_y;
		logic [7:0] entry_quality;
		logic [7:0] entry_seen;
		logic [7:0] batch_count;
		logic last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXPIRE, ST_SCAN1, ST_SCAN2, ST_APPLY, ST_SORT,
		ST_EMIT, ST_SIMPLE, ST_OUT
	} state_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic load_req;
		logic clr_idx;
		logic inc_idx;
		logic expire_en;
		logic scan1_en;
		logic scan2_en;
		logic apply_en;
		logic sort_en;
		logic emit_en;
		logic simple_en;
	} cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic idx_last;
		logic emit_done;
		logic skip_expire;
		logic dropped;
		logic need_scan;
		logic is_list;
	} sts_t;
endpackage

FILE: hw/rtl/ttt_ctrl.sv
// Controller state machine for the target track table.
// Depends on ttt_pkg.
module ttt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_busy,
	input  ttt_pkg::sts_t sts,
	output ttt_pkg::cmd_t cmd,
	output logic in_ready
);
	ttt_pkg::state_t state_q, state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttt_pkg::ST_IDLE: if (in_fire) state_d = ttt_pkg::ST_EXPIRE;
			ttt_pkg::ST_EXPIRE: begin
				if (sts.skip_expire || sts.idx_last)
					state_d = sts.need_scan ? ttt_pkg::ST_SCAN1 :
						(sts.is_list ? ttt_pkg::ST_SORT : ttt_pkg::ST_SIMPLE);
				if (sts.skip_expire && sts.is_list) state_d = ttt_pkg::ST_EMIT;
			end
			ttt_pkg::ST_SCAN1: if (sts.idx_last) state_d = ttt_pkg::ST_SCAN2;
			ttt_pkg::ST_SCAN2: if (sts.idx_last) state_d = ttt_pkg::ST_APPLY;
			ttt_pkg::ST_APPLY: state_d = ttt_pkg::ST_OUT;
			ttt_pkg::ST_SORT: if (sts.idx_last) state_d = ttt_pkg::ST_EMIT;
			// final list entry still has to leave before the next request
			ttt_pkg::ST_EMIT: if (!out_busy && sts.emit_done) state_d = ttt_pkg::ST_OUT;
			ttt_pkg::ST_SIMPLE: state_d = ttt_pkg::ST_OUT;
			ttt_pkg::ST_OUT: if (!out_busy) state_d = ttt_pkg::ST_IDLE;
			default: state_d = ttt_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ttt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_req = in_fire;
				cmd.clr_idx = 1'b1;
			end
			ttt_pkg::ST_EXPIRE: begin
				cmd.expire_en = !sts.skip_expire;
				cmd.inc_idx = 1'b1;
				if (sts.skip_expire || sts.idx_last) cmd.clr_idx = 1'b1;
			end
			ttt_pkg::ST_SCAN1: begin
				cmd.scan1_en = 1'b1;
				cmd.inc_idx = 1'b1;
				if (sts.idx_last) cmd.clr_idx = 1'b1;
			end
			ttt_pkg::ST_SCAN2: begin
				cmd.scan2_en = 1'b1;
				cmd.inc_idx = 1'b1;
				if (sts.idx_last) cmd.clr_idx = 1'b1;
			end
			ttt_pkg::ST_APPLY: cmd.apply_en = 1'b1;
			ttt_pkg::ST_SORT: begin
				cmd.sort_en = 1'b1;
				cmd.inc_idx = 1'b1;
				if (sts.idx_last) cmd.clr_idx = 1'b1;
			end
			ttt_pkg::ST_EMIT: cmd.emit_en = !out_busy;
			ttt_pkg::ST_SIMPLE: cmd.simple_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ttt_pkg::ST_IDLE;
		else state_q <= state_d;
	end
endmodule

FILE: hw/rtl/ttt_dp.sv
// Datapath for the target track table: slot registers, scan, sort, results.
// Depends on ttt_pkg.
module ttt_dp #(
	parameter int DEPTH = ttt_pkg::TABLE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  ttt_pkg::cmd_t cmd,
	input  ttt_pkg::req_t req,
	input  logic [14:0] radius,
	input  logic [31:0] expiry,
	input  logic [7:0] batch_lim,
	output ttt_pkg::sts_t sts,
	output ttt_pkg::rsp_t rsp
);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [1:0]  flags_q [DEPTH];
	logic [15:0] ident_q [DEPTH];
	logic [7:0]  color_q [DEPTH];
	logic [15:0] x_q [DEPTH];
	logic [15:0] y_q [DEPTH];
	logic [7:0]  qual_q [DEPTH];
	logic [7:0]  seen_q [DEPTH];
	logic [31:0] time_q [DEPTH];
	logic [15:0] next_id_q;
	logic [7:0]  total_q;

	ttt_pkg::req_t r_q;
	logic [IW-1:0] idx_q;
	logic [31:0] best_q;
	logic match_v_q, free_v_q, old_v_q, drop_q;
	logic [IW-1:0] match_q, free_q, old_q;
	logic [31:0] old_age_q;
	// sorted list of slot indices, insertion sort one slot per cycle
	logic [IW-1:0] srt_q [DEPTH];
	logic [33:0]  sd_q [DEPTH];
	logic [CW-1:0] n_q, emit_q;
	ttt_pkg::rsp_t res_q;

	// current slot distance
	logic signed [16:0] dx, dy;
	logic [33:0] d2, rad2;
	logic pend, held;
	logic [31:0] age;
	logic [4:0] lim;
	always_comb begin
		dx = 17'($signed(x_q[idx_q])) - 17'(r_q.pos_x);
		dy = 17'($signed(y_q[idx_q])) - 17'(r_q.pos_y);
		d2 = 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
		rad2 = 34'(radius) * 34'(radius);
		pend = flags_q[idx_q] == 2'b01;
		held = flags_q[idx_q] == 2'b11;
		age = r_q.now_ms - time_q[idx_q];
		lim = (r_q.list_limit > 5'(ttt_pkg::MAX_RESULTS)) ? 5'(ttt_pkg::MAX_RESULTS)
			: r_q.list_limit;
	end

	// insertion position: count sorted entries that precede the new one
	logic [CW-1:0] pos;
	always_comb begin
		pos = '0;
		for (int k = 0; k < DEPTH; k++)
			if (CW'(k) < n_q && (sd_q[k] < d2 ||
				(sd_q[k] == d2 && ident_q[srt_q[k]] < ident_q[idx_q])))
				pos = CW'(k + 1);
	end

	always_comb begin
		sts.idx_last = idx_q == IW'(DEPTH - 1);
		sts.emit_done = (8'(emit_q) + 8'd1 >= 8'(lim)) || (8'(emit_q) + 8'd1 >= 8'(n_q));
		sts.is_list = r_q.func == ttt_pkg::FN_LIST;
		sts.need_scan = r_q.func == ttt_pkg::FN_OBSERVE && !drop_q;
		sts.dropped = drop_q;
		sts.skip_expire = drop_q || (sts.is_list && lim == '0) ||
			!(r_q.func == ttt_pkg::FN_OBSERVE || r_q.func == ttt_pkg::FN_FIND ||
			r_q.func == ttt_pkg::FN_LIST);
	end

	function automatic ttt_pkg::rsp_t mk(input logic f, input logic [15:0] id,
		input logic [7:0] c, input logic [15:0] x, input logic [15:0] y,
		input logic [7:0] q, input logic [7:0] s, input logic [7:0] t, input logic l);
		ttt_pkg::rsp_t o;
		o.found = f; o.entry_id = id; o.entry_color = c; o.entry_x = x; o.entry_y = y;
		o.entry_quality = q; o.entry_seen = s; o.batch_count = t; o.last = l;
		return o;
	endfunction

	// find first pending slot with id (used by find, mark and forget)
	logic hit_v;
	logic [IW-1:0] hit_i;
	always_comb begin
		hit_v = 1'b0;
		hit_i = '0;
		for (int k = DEPTH - 1; k >= 0; k--)
			if (flags_q[k] == 2'b01 && ident_q[k] == r_q.target_id) begin
				hit_v = 1'b1;
				hit_i = IW'(k);
			end
	end

	assign rsp = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) flags_q[k] <= '0;
			next_id_q <= 16'd1;
			total_q <= '0;
			idx_q <= '0;
			drop_q <= 1'b0;
			n_q <= '0;
			emit_q <= '0;
		end else begin
			if (cmd.clr_idx) idx_q <= '0;
			else if (cmd.inc_idx) idx_q <= idx_q + 1'b1;
			if (cmd.load_req) begin
				r_q <= req;
				drop_q <= req.func == ttt_pkg::FN_OBSERVE && total_q >= batch_lim;
				best_q <= 32'(radius) * 32'(radius);
				match_v_q <= 1'b0;
				free_v_q <= 1'b0;
				old_v_q <= 1'b0;
				n_q <= '0;
				emit_q <= '0;
			end
			if (cmd.expire_en && pend && age > expiry) flags_q[idx_q] <= 2'b00;
			if (cmd.scan1_en && held && color_q[idx_q] == r_q.color && d2 <= rad2)
				drop_q <= 1'b1;
			if (cmd.scan2_en && !drop_q) begin
				if (!flags_q[idx_q][0]) begin
					if (!free_v_q) begin free_v_q <= 1'b1; free_q <= idx_q; end
				end else if (!flags_q[idx_q][1]) begin
					if (!old_v_q || age > old_age_q) begin
						old_v_q <= 1'b1; old_q <= idx_q; old_age_q <= age;
					end
					if (color_q[idx_q] == r_q.color && d2 <= {2'b0, best_q}) begin
						best_q <= d2[31:0]; match_v_q <= 1'b1; match_q <= idx_q;
					end
				end
			end
			if (cmd.apply_en) begin
				if (drop_q) res_q <= mk(0, '0, '0, '0, '0, '0, '0, total_q, 1'b1);
				else if (match_v_q) begin
					x_q[match_q] <= r_q.pos_x; y_q[match_q] <= r_q.pos_y;
					qual_q[match_q] <= r_q.quality; time_q[match_q] <= r_q.now_ms;
					if (seen_q[match_q] < ttt_pkg::SEEN_MAX)
						seen_q[match_q] <= seen_q[match_q] + 1'b1;
					res_q <= mk(1, ident_q[match_q], color_q[match_q], r_q.pos_x,
						r_q.pos_y, r_q.quality, (seen_q[match_q] < ttt_pkg::SEEN_MAX) ?
						seen_q[match_q] + 1'b1 : seen_q[match_q], total_q, 1'b1);
				end else if (free_v_q || old_v_q) begin
					automatic logic [IW-1:0] s = free_v_q ? free_q : old_q;
					ident_q[s] <= next_id_q;
					next_id_q <= (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 1'b1;
					flags_q[s] <= 2'b01; seen_q[s] <= 8'd1; color_q[s] <= r_q.color;
					qual_q[s] <= r_q.quality; x_q[s] <= r_q.pos_x; y_q[s] <= r_q.pos_y;
					time_q[s] <= r_q.now_ms;
					res_q <= mk(1, next_id_q, r_q.color, r_q.pos_x, r_q.pos_y,
						r_q.quality, 8'd1, total_q, 1'b1);
				end else res_q <= mk(0, '0, '0, '0, '0, '0, '0, total_q, 1'b1);
			end
			// insertion sort step
			if (cmd.sort_en && pend) begin
				for (int k = DEPTH - 1; k > 0; k--)
					if (CW'(k) > pos && CW'(k) <= n_q) begin
						srt_q[k] <= srt_q[k-1]; sd_q[k] <= sd_q[k-1];
					end
				srt_q[pos[IW-1:0]] <= idx_q;
				sd_q[pos[IW-1:0]] <= d2;
				n_q <= n_q + 1'b1;
			end
			if (cmd.emit_en) begin
				emit_q <= emit_q + 1'b1;
				if (n_q == '0 || lim == '0)
					res_q <= mk(0, '0, '0, '0, '0, '0, '0, total_q, 1'b1);
				else res_q <= mk(1, ident_q[srt_q[emit_q[IW-1:0]]],
					color_q[srt_q[emit_q[IW-1:0]]], x_q[srt_q[emit_q[IW-1:0]]],
					y_q[srt_q[emit_q[IW-1:0]]], qual_q[srt_q[emit_q[IW-1:0]]],
					seen_q[srt_q[emit_q[IW-1:0]]], total_q, sts.emit_done);
			end
			if (cmd.simple_en) begin
				unique case (ttt_pkg::func_t'(r_q.func))
					ttt_pkg::FN_FIND: res_q <= hit_v ? mk(1, ident_q[hit_i],
						color_q[hit_i], x_q[hit_i], y_q[hit_i], qual_q[hit_i],
						seen_q[hit_i], total_q, 1'b1)
						: mk(0, '0, '0, '0, '0, '0, '0, total_q, 1'b1);
					ttt_pkg::FN_MARK: begin
						if (hit_v && total_q < batch_lim) begin
							flags_q[hit_i] <= 2'b11;
							total_q <= total_q + 1'b1;
							res_q <= mk(1, ident_q[hit_i], color_q[hit_i], x_q[hit_i],
								y_q[hit_i], qual_q[hit_i], seen_q[hit_i],
								total_q + 1'b1, 1'b1);
						end else res_q <= mk(0, '0, '0, '0, '0, '0, '0, total_q, 1'b1);
					end
					ttt_pkg::FN_FORGET: begin
						for (int k = 0; k < DEPTH; k++)
							if (flags_q[k] == 2'b01 && ident_q[k] == r_q.target_id)
								flags_q[k] <= 2'b00;
						res_q <= mk(hit_v, r_q.target_id, '0, '0, '0, '0, '0,
							total_q, 1'b1);
					end
					ttt_pkg::FN_CLEAR: begin
						for (int k = 0; k < DEPTH; k++)
							if (!flags_q[k][1]) flags_q[k] <= 2'b00;
						res_q <= mk(1, '0, '0, '0, '0, '0, '0, total_q, 1'b1);
					end
					ttt_pkg::FN_RESET: begin
						for (int k = 0; k < DEPTH; k++) flags_q[k] <= 2'b00;
						next_id_q <= 16'd1;
						total_q <= '0;
						res_q <= mk(1, '0, '0, '0, '0, '0, '0, 8'd0, 1'b1);
					end
					ttt_pkg::FN_PICKUP: begin
						if (total_q < batch_lim) begin
							total_q <= total_q + 1'b1;
							res_q <= mk(1, '0, '0, '0, '0, '0, '0, total_q + 1'b1, 1'b1);
						end else res_q <= mk(0, '0, '0, '0, '0, '0, '0, total_q, 1'b1);
					end
					default: res_q <= mk(0, '0, '0, '0, '0, '0, '0, total_q, 1'b1);
				endcase
			end
		end
	end
endmodule

FILE: hw/rtl/target_track_table_top.sv
// Target track table top level: config registers, ttt_ctrl, ttt_dp (ttt_pkg types).
// Flow: observe runs expire, two slot scans, apply; list runs expire, sort, emit; find
// runs expire, lookup; the rest, a dropped observe and a zero-limit list skip expire.
// Throughput: one request at a time, set by the per-slot scans; list results follow
// one per cycle while out_stall is low; a new request waits for the last to leave.
// Reset (arst_n low): all slots invalid, next id 1, count 0, registers default.
module target_track_table_top #(
	parameter int TABLE_DEPTH = ttt_pkg::TABLE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  ttt_pkg::req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output ttt_pkg::rsp_t out_data,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	logic [14:0] radius_q;
	logic [31:0] expiry_q;
	logic [7:0] batch_q;
	logic in_ready, out_v_q, in_fire;
	ttt_pkg::cmd_t cmd;
	ttt_pkg::sts_t sts;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 15'd100; expiry_q <= 32'd1000; batch_q <= 8'd6;
		end else if (cfg_we) begin
			unique case (ttt_pkg::cfg_idx_t'(cfg_index))
				ttt_pkg::CFG_RADIUS: radius_q <= cfg_data[14:0];
				ttt_pkg::CFG_EXPIRY: expiry_q <= cfg_data;
				ttt_pkg::CFG_BATCH: batch_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign in_fire = in_valid && in_ready;
	assign in_stall = !in_ready;

	// Output valid: set when a result is written, held until transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (cmd.apply_en || cmd.simple_en || cmd.emit_en) out_v_q <= 1'b1;
		else if (!out_stall) out_v_q <= 1'b0;
	end
	assign out_valid = out_v_q;

	ttt_ctrl u_ctrl (.clk, .arst_n, .in_fire, .out_busy(out_v_q && out_stall),
		.sts, .cmd, .in_ready);

	ttt_dp #(.DEPTH(TABLE_DEPTH)) u_dp (.clk, .arst_n, .cmd, .req(in_data),
		.radius(radius_q), .expiry(expiry_q), .batch_lim(batch_q), .sts, .rsp(out_data));
endmodule

FILE: hw/rtl/target_track_table_chk.sv
// Port-level checker for target_track_table_top, bound to the top level.
// Depends on ttt_pkg and target_track_table_top_defines.svh.
`include "target_track_table_top_defines.svh"
module target_track_table_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input ttt_pkg::rsp_t out_data
);
	`TTT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
	`TTT_ASSERT_IMP(a_busy_no_take, clk, arst_n, out_valid && !out_data.last, in_stall, "request taken mid-list")
	`TTT_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, in_stall, "second request taken at once")
endmodule

bind target_track_table_top target_track_table_chk u_chk (.clk, .arst_n, .in_valid,
	.in_stall, .out_valid, .out_stall, .out_data);
